>>> src/llg_pkg.sv
// ----------------------------------------------------------------------------
// llg_pkg: shared widths, types and helpers for the LLG torque step block
// Fixed-point widths of every pipeline intermediate, chosen so that no
// intermediate can overflow for any input bit pattern.
// ----------------------------------------------------------------------------
package llg_pkg;

    localparam int MAG_W   = 16;  // Q1.15 magnetization
    localparam int FIELD_W = 24;  // Q8.15 effective field
    localparam int OUT_W   = 24;  // Q8.15 result
    localparam int CFG_W   = 16;  // Q0.16 registers
    localparam int IDX_W   = 1;   // register index

    localparam int PH_W  = MAG_W + FIELD_W;   // m*h product, 2^-30
    localparam int C_W   = PH_W + 1;          // c = m x h, 2^-30
    localparam int MC_W  = MAG_W + C_W;       // m*c product and difference, 2^-45
    localparam int D_SH  = 15;                // 2^-45 to 2^-30
    localparam int D_W   = MC_W - D_SH;       // d, 2^-30
    localparam int AD_W  = CFG_W + 1 + D_W;   // alpha*d, 2^-46
    localparam int SUM_W = AD_W + 1;          // c*2^16 + alpha*d, 2^-46
    localparam int S_SH  = 16;                // 2^-46 to 2^-30
    localparam int S_W   = SUM_W - S_SH;      // s, 2^-30
    localparam int DS_W  = CFG_W + 1 + S_W;   // dt*s, 2^-46
    localparam int R_SH  = 31;                // 2^-46 to 2^-15
    localparam int R_W   = DS_W - R_SH;       // unsaturated result

    localparam int NSTG  = 8;                 // pipeline depth
    localparam int STG_W = $clog2(NSTG);

    localparam logic [IDX_W-1:0] REG_DAMPING   = 1'b0;
    localparam logic [IDX_W-1:0] REG_TIME_STEP = 1'b1;
    localparam logic [CFG_W-1:0] DAMPING_RST   = CFG_W'(655);
    localparam logic [CFG_W-1:0] TIME_STEP_RST = CFG_W'(655);

    typedef logic signed [MAG_W-1:0]   t_mag;
    typedef logic signed [FIELD_W-1:0] t_field;
    typedef logic signed [OUT_W-1:0]   t_out;
    typedef logic signed [PH_W-1:0]    t_ph;
    typedef logic signed [C_W-1:0]     t_c;
    typedef logic signed [MC_W-1:0]    t_mc;
    typedef logic signed [D_W-1:0]     t_d;
    typedef logic signed [AD_W-1:0]    t_ad;
    typedef logic signed [SUM_W-1:0]   t_sum;
    typedef logic signed [S_W-1:0]     t_s;
    typedef logic signed [DS_W-1:0]    t_ds;
    typedef logic signed [R_W-1:0]     t_r;

    // Cyclic neighbours of a vector component, for the cross products.
    typedef logic [1:0] t_cidx;
    localparam t_cidx NEXT1 [3] = '{2'd1, 2'd2, 2'd0};
    localparam t_cidx NEXT2 [3] = '{2'd2, 2'd0, 2'd1};

    localparam t_mc  MC_HALF  = t_mc'(1)  <<< (D_SH - 1);
    localparam t_sum SUM_HALF = t_sum'(1) <<< (S_SH - 1);
    localparam t_ds  DS_HALF  = t_ds'(1)  <<< (R_SH - 1);

    localparam t_r OUT_MAX = t_r'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
    localparam t_r OUT_MIN = t_r'(-(64'sd1 <<< (OUT_W - 1)));

    // Clip a rounded result to the output range.
    function automatic t_out sat_out(input t_r v);
        t_out res;
        if (v > OUT_MAX) begin
            res = t_out'(OUT_MAX);
        end else if (v < OUT_MIN) begin
            res = t_out'(OUT_MIN);
        end else begin
            res = t_out'(v);
        end
        return res;
    endfunction

endpackage

>>> src/llg_torque_step_core.sv
// ----------------------------------------------------------------------------
// llg_torque_step_core: pipelined Landau-Lifshitz-Gilbert torque step
// Returns dt*(m x h - alpha * m x (m x h)) per cell in fixed point.
// ----------------------------------------------------------------------------
// Usage:
// One item on the input channel (i_valid / o_ready) is one cell: the
// magnetization m (Q1.15), the effective field h (Q8.15) and a last-cell
// flag. Each item gives exactly one item on the output channel
// (o_valid / i_ready): the saturated Q8.15 change and the flag, unchanged.
// The two registers, damping alpha and time step dt (both unsigned Q0.16),
// are written through i_cfg_we / i_cfg_idx / i_cfg_data while no item is
// in flight; both reset to 655.
// The datapath is an eight-stage pipeline: two stages for m x h, two for
// m x c, two for the sum with alpha, one for the dt product and one for
// rounding and saturation. One item can be accepted in every cycle while
// i_ready stays high, so throughput is then one item per cycle. Each stage
// holds its item while the stage after it is full and stalled, so bubbles
// are squeezed out and a stalled receiver holds the result steady in the
// output register without losing or repeating anything. Reset empties
// every stage and restores the register defaults.
// ----------------------------------------------------------------------------
module llg_torque_step_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // configuration write port
    input  logic                            i_cfg_we,
    input  logic [llg_pkg::IDX_W-1:0]       i_cfg_idx,
    input  logic [llg_pkg::CFG_W-1:0]       i_cfg_data,
    // input channel
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic signed [llg_pkg::MAG_W-1:0]   i_mag_x,
    input  logic signed [llg_pkg::MAG_W-1:0]   i_mag_y,
    input  logic signed [llg_pkg::MAG_W-1:0]   i_mag_z,
    input  logic signed [llg_pkg::FIELD_W-1:0] i_field_x,
    input  logic signed [llg_pkg::FIELD_W-1:0] i_field_y,
    input  logic signed [llg_pkg::FIELD_W-1:0] i_field_z,
    input  logic                            i_last_cell,
    // output channel
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic signed [llg_pkg::OUT_W-1:0]   o_delta_x,
    output logic signed [llg_pkg::OUT_W-1:0]   o_delta_y,
    output logic signed [llg_pkg::OUT_W-1:0]   o_delta_z,
    output logic                            o_end_of_mesh
);

    // Configuration registers.
    logic [llg_pkg::CFG_W-1:0] r_damping;
    logic [llg_pkg::CFG_W-1:0] r_time_step;

    // Per-stage occupancy and the enable chain running back from the output.
    logic                r_vld  [llg_pkg::NSTG];
    logic                r_last [llg_pkg::NSTG];
    logic                w_en   [llg_pkg::NSTG];

    // Vector views of the input item.
    llg_pkg::t_mag       w_m [3];
    llg_pkg::t_field     w_h [3];

    // Stage 1: m*h products; m carried along.
    llg_pkg::t_ph        r_p    [6];
    llg_pkg::t_mag       r_m_s1 [3];
    // Stage 2: c = m x h.
    llg_pkg::t_c         r_c_s2 [3];
    llg_pkg::t_mag       r_m_s2 [3];
    // Stage 3: m*c products.
    llg_pkg::t_mc        r_q    [6];
    llg_pkg::t_c         r_c_s3 [3];
    // Stage 4: d = -(m x c), rounded.
    llg_pkg::t_d         r_d    [3];
    llg_pkg::t_c         r_c_s4 [3];
    // Stage 5: alpha*d.
    llg_pkg::t_ad        r_ad   [3];
    llg_pkg::t_c         r_c_s5 [3];
    // Stage 6: s = c + alpha*d, rounded.
    llg_pkg::t_s         r_s    [3];
    // Stage 7: dt*s.
    llg_pkg::t_ds        r_ds   [3];
    // Stage 8: rounded and saturated result.
    llg_pkg::t_out       r_out  [3];

    // Combinational intermediates.
    llg_pkg::t_mc        w_mc_diff [3];
    llg_pkg::t_sum       w_sum     [3];
    llg_pkg::t_ds        w_ds_rnd  [3];
    llg_pkg::t_r         w_r       [3];

    assign w_m[0] = i_mag_x;
    assign w_m[1] = i_mag_y;
    assign w_m[2] = i_mag_z;
    assign w_h[0] = i_field_x;
    assign w_h[1] = i_field_y;
    assign w_h[2] = i_field_z;

    // ---------------------------------------------------------------------
    // Configuration. Writes to an unused index are dropped.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_damping   <= llg_pkg::DAMPING_RST;
            r_time_step <= llg_pkg::TIME_STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                llg_pkg::REG_DAMPING:   r_damping   <= i_cfg_data;
                llg_pkg::REG_TIME_STEP: r_time_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Flow control. A stage may load when it is empty or when the stage
    // after it is moving on, so a stall only backs up as far as the first
    // empty stage.
    // ---------------------------------------------------------------------
    always_comb begin
        w_en[llg_pkg::NSTG-1] = !r_vld[llg_pkg::NSTG-1] || i_ready;
        for (int s = llg_pkg::NSTG - 2; s >= 0; s--) begin
            w_en[s] = !r_vld[s] || w_en[s+1];
        end
    end

    assign o_ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < llg_pkg::NSTG; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int s = 1; s < llg_pkg::NSTG; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // The last-cell flag rides alongside the data.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_last[0] <= i_last_cell;
        end
        for (int s = 1; s < llg_pkg::NSTG; s++) begin
            if (w_en[s]) begin
                r_last[s] <= r_last[s-1];
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath rounding steps: add half an LSB, then an arithmetic shift,
    // which floors.
    // ---------------------------------------------------------------------
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_mc_diff[k] = r_q[2*k] - r_q[2*k+1] + llg_pkg::MC_HALF;
            w_sum[k]     = (llg_pkg::t_sum'(r_c_s5[k]) <<< llg_pkg::S_SH)
                         + llg_pkg::t_sum'(r_ad[k]) + llg_pkg::SUM_HALF;
            w_ds_rnd[k]  = r_ds[k] + llg_pkg::DS_HALF;
            w_r[k]       = w_ds_rnd[k][llg_pkg::DS_W-1:llg_pkg::R_SH];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            // Stage 1: the six products of m x h.
            if (w_en[0]) begin
                r_p[2*k]   <= llg_pkg::t_ph'(w_m[llg_pkg::NEXT1[k]])
                            * llg_pkg::t_ph'(w_h[llg_pkg::NEXT2[k]]);
                r_p[2*k+1] <= llg_pkg::t_ph'(w_m[llg_pkg::NEXT2[k]])
                            * llg_pkg::t_ph'(w_h[llg_pkg::NEXT1[k]]);
                r_m_s1[k]  <= w_m[k];
            end
            // Stage 2: precession term.
            if (w_en[1]) begin
                r_c_s2[k] <= llg_pkg::t_c'(r_p[2*k]) - llg_pkg::t_c'(r_p[2*k+1]);
                r_m_s2[k] <= r_m_s1[k];
            end
            // Stage 3: the six products of m x c, in the order that gives
            // the damping term -(m x c) directly.
            if (w_en[2]) begin
                r_q[2*k]   <= llg_pkg::t_mc'(r_m_s2[llg_pkg::NEXT2[k]])
                            * llg_pkg::t_mc'(r_c_s2[llg_pkg::NEXT1[k]]);
                r_q[2*k+1] <= llg_pkg::t_mc'(r_m_s2[llg_pkg::NEXT1[k]])
                            * llg_pkg::t_mc'(r_c_s2[llg_pkg::NEXT2[k]]);
                r_c_s3[k]  <= r_c_s2[k];
            end
            // Stage 4: damping term rounded to 2^-30.
            if (w_en[3]) begin
                r_d[k]    <= w_mc_diff[k][llg_pkg::MC_W-1:llg_pkg::D_SH];
                r_c_s4[k] <= r_c_s3[k];
            end
            // Stage 5: alpha times the damping term.
            if (w_en[4]) begin
                r_ad[k]   <= llg_pkg::t_ad'($signed({1'b0, r_damping}))
                           * llg_pkg::t_ad'(r_d[k]);
                r_c_s5[k] <= r_c_s4[k];
            end
            // Stage 6: torque sum rounded to 2^-30.
            if (w_en[5]) begin
                r_s[k] <= w_sum[k][llg_pkg::SUM_W-1:llg_pkg::S_SH];
            end
            // Stage 7: scale by the time step.
            if (w_en[6]) begin
                r_ds[k] <= llg_pkg::t_ds'($signed({1'b0, r_time_step}))
                         * llg_pkg::t_ds'(r_s[k]);
            end
            // Stage 8: round to Q8.15 and clip.
            if (w_en[7]) begin
                r_out[k] <= llg_pkg::sat_out(w_r[k]);
            end
        end
    end

    assign o_valid       = r_vld[llg_pkg::NSTG-1];
    assign o_delta_x     = r_out[0];
    assign o_delta_y     = r_out[1];
    assign o_delta_z     = r_out[2];
    assign o_end_of_mesh = r_last[llg_pkg::NSTG-1];

    // ---------------------------------------------------------------------
    // Checks.
    // ---------------------------------------------------------------------
    // With the output register empty the whole enable chain is open.
    a_empty_out_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input not ready although the output stage is empty");

    // An accepted item always lands in the first stage.
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted item did not enter the pipeline");

    // A held mid-pipeline stage keeps its item.
    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !w_en[3]) |=> r_vld[3])
        else $error("stalled pipeline stage dropped its item");

    // Stalls propagate only through full stages.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_vld[0] && o_valid && !i_ready))
        else $error("input stalled without a full pipeline behind it");

endmodule
